// File: hw/rtl/gdc_pkg.sv
// Shared types, constants and month tables for the Gregorian date / day
// number converter. Used by gregorian_date_day_number_converter_unit.
// No dependencies.
`default_nettype none

package gdc_pkg;

	// Field widths
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int CNT_W   = 23;
	localparam int Z_W     = 22;   // shifted count, 306..3652364 over the accepted span
	localparam int DOE_W   = 18;   // day of era, 0..146096
	localparam int YOE_W   = 9;    // year of era, 0..399
	localparam int DOY_W   = 9;    // day of March-based year, 0..365
	localparam int ERA_W   = 5;    // era index, 0..24

	// Calendar constants
	localparam int unsigned YEAR_MAX   = 9999;
	localparam int unsigned EPOCH_OFS  = 719468;   // 0000-03-01 to 1970-01-01
	localparam int unsigned ERA_DAYS   = 146097;   // days in 400 years
	localparam int unsigned YEAR_DAYS  = 365;
	localparam int unsigned ERA_YEARS  = 400;
	localparam int unsigned CENT_YEARS = 100;

	// Accepted day-count span: 0001-01-01 .. 9999-12-31
	localparam logic signed [CNT_W-1:0] CNT_LO = -23'sd719162;
	localparam logic signed [CNT_W-1:0] CNT_HI = 23'sd2932896;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_YEAR  = 3'd1,
		ST_BAD_MONTH = 3'd2,
		ST_DAY_ZERO  = 3'd3,
		ST_DAY_OVER  = 3'd4,
		ST_SPAN      = 3'd5
	} status_t;

	// First day (0-based) of each month in a year that starts in March
	function automatic logic [DOY_W-1:0] march_start(input logic [MONTH_W-1:0] mp);
		logic [DOY_W-1:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Length of a civil month, January = 1
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		case (m) inside
			4'd2:                    r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default:                 r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gdc_cdiv.sv
// Unsigned divide by a constant through a reciprocal multiply.
// Combinational; exact for every N-bit dividend. No dependencies.
`default_nettype none

module gdc_cdiv #(
	parameter int          N  = 18,      // dividend width
	parameter int unsigned D  = 365,     // divisor
	parameter int          QW = 9        // quotient width kept
) (
	input  logic [N-1:0]  x,
	output logic [QW-1:0] q
);

	// m = ceil(2^K / D) with K = N + ceil(log2 D) gives an exact quotient
	localparam int              L    = $clog2(D);
	localparam int              K    = N + L;
	localparam int              MW   = N + 2;
	localparam longint unsigned Pow  = 64'd1 << K;
	localparam longint unsigned Mraw = (Pow + longint'(D) - 64'd1) / longint'(D);
	localparam logic [MW-1:0]   MulC = MW'(Mraw);

	logic [N+MW-1:0] prod;

	assign prod = {{MW{1'b0}}, x} * {{N{1'b0}}, MulC};
	assign q    = prod[K +: QW];

endmodule

`default_nettype wire

// File: hw/rtl/gregorian_date_day_number_converter_unit.sv
// Gregorian date <-> day number converter, top level.
// Each beat is registered through stages 1 to 9 and its result is shown with done.
// Throughput: one beat per cycle; busy is always low since the 9-stage pipeline
// never stalls and the receiver cannot hold results off.
// Reset: arst_n clears the stage valid bits only; nothing needs a clearing pass.
// Depends on gdc_pkg and gdc_cdiv.
`default_nettype none

module gregorian_date_day_number_converter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                req_type,
	input  logic [gdc_pkg::YEAR_W-1:0]          in_year,
	input  logic [gdc_pkg::MONTH_W-1:0]         in_month,
	input  logic [gdc_pkg::DAY_W-1:0]           in_day,
	input  logic signed [gdc_pkg::CNT_W-1:0]    in_day_count,
	output logic                                done,
	output logic [2:0]                          status,
	output logic signed [gdc_pkg::CNT_W-1:0]    out_day_count,
	output logic [gdc_pkg::YEAR_W-1:0]          out_year,
	output logic [gdc_pkg::MONTH_W-1:0]         out_month,
	output logic [gdc_pkg::DAY_W-1:0]           out_day
);

	import gdc_pkg::*;

	// ---------------- stage registers ----------------
	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic                rev_s1, rev_s2, rev_s3, rev_s4, rev_s5, rev_s6, rev_s7, rev_s8;
	status_t             st_s2, st_s3, st_s4, st_s5, st_s6, st_s7, st_s8;
	logic [CNT_W-1:0]    cnt_s1, cnt_s2, cnt_s3, cnt_s4, cnt_s5, cnt_s6, cnt_s7, cnt_s8;

	logic [YEAR_W-1:0]   y_s1, yy_s1;
	logic [MONTH_W-1:0]  m_s1;
	logic [DAY_W-1:0]    d_s1;
	logic [7:0]          qy_s1, qyy_s1;
	logic                span_bad_s1;
	logic [Z_W-1:0]      z_s1, z_s2;

	logic [ERA_W-1:0]    era_s2, era_s3, era_s4, era_s5, era_s6;
	logic [YOE_W-1:0]    yoe_s2, yoe_s6;
	logic [1:0]          yhi_s2;
	logic [DOY_W-1:0]    doy_s2, doy_s7, doy_s8;
	logic [Z_W-1:0]      edays_s3;
	logic [DOE_W-1:0]    doe_s3, doe_s4, doe_s5, doe_s6;
	logic [6:0]          qa_s4;
	logic [2:0]          qb_s4;
	logic                qc_s4;
	logic [DOE_W-1:0]    t_s5;
	logic [YEAR_W-1:0]   yy_s7, yy_s8;
	logic [MONTH_W-1:0]  mp_s8;

	status_t             st_s9;
	logic [CNT_W-1:0]    cnt_s9;
	logic [YEAR_W-1:0]   year_s9;
	logic [MONTH_W-1:0]  month_s9;
	logic [DAY_W-1:0]    day_s9;

	// The pipeline takes a beat every cycle
	assign busy = 1'b0;

	// ---------------- valid chain ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			v_s8 <= v_s7; v_s9 <= v_s8;
		end
	end

	// ---------------- stage 1: year quotients, span check ----------------
	logic               early_in;
	logic [YEAR_W-1:0]  yy_in;
	logic [7:0]         qy_in, qyy_in;
	logic [CNT_W-1:0]   zw_in;
	logic               span_bad_in;

	assign early_in    = (in_month <= 4'd2);
	assign yy_in       = in_year - YEAR_W'(early_in);
	assign span_bad_in = (in_day_count < CNT_LO) || (in_day_count > CNT_HI);
	assign zw_in       = in_day_count + CNT_W'(EPOCH_OFS);

	gdc_cdiv #(.N(YEAR_W), .D(CENT_YEARS), .QW(8)) u_div_y (.x(in_year), .q(qy_in));
	gdc_cdiv #(.N(YEAR_W), .D(CENT_YEARS), .QW(8)) u_div_yy (.x(yy_in), .q(qyy_in));

	always_ff @(posedge clk) begin
		rev_s1      <= req_type;
		y_s1        <= in_year;
		m_s1        <= in_month;
		d_s1        <= in_day;
		yy_s1       <= yy_in;
		qy_s1       <= qy_in;
		qyy_s1      <= qyy_in;
		span_bad_s1 <= span_bad_in;
		z_s1        <= zw_in[Z_W-1:0];
		cnt_s1      <= in_day_count;
	end

	// ---------------- stage 2: checks, era, day of year / era index ----------------
	logic [YEAR_W-1:0]  rem_y;
	logic               leap;
	status_t            st_f;
	logic [ERA_W-1:0]   era_f, era_r;
	logic [YEAR_W-1:0]  era_yrs;
	logic [MONTH_W-1:0] mm_f;
	logic [DOY_W-1:0]   doy_f;

	assign rem_y   = y_s1 - YEAR_W'(qy_s1 * 7'd100);
	assign leap    = (y_s1[1:0] == 2'd0) && ((rem_y != '0) || (qy_s1[1:0] == 2'd0));
	assign era_f   = qyy_s1[6:2];
	assign era_yrs = YEAR_W'(era_f * 9'(ERA_YEARS));
	assign mm_f    = (m_s1 > 4'd2) ? (m_s1 - 4'd3) : (m_s1 + 4'd9);
	assign doy_f   = march_start(mm_f) + DOY_W'(d_s1) - 9'd1;

	// First failed check wins
	always_comb begin
		if (y_s1 == '0 || y_s1 > YEAR_W'(YEAR_MAX))
			st_f = ST_BAD_YEAR;
		else if (m_s1 == '0 || m_s1 > 4'd12)
			st_f = ST_BAD_MONTH;
		else if (d_s1 == '0)
			st_f = ST_DAY_ZERO;
		else if (d_s1 > month_len(m_s1, leap))
			st_f = ST_DAY_OVER;
		else
			st_f = ST_OK;
	end

	gdc_cdiv #(.N(Z_W), .D(ERA_DAYS), .QW(ERA_W)) u_div_era (.x(z_s1), .q(era_r));

	always_ff @(posedge clk) begin
		rev_s2 <= rev_s1;
		st_s2  <= rev_s1 ? (span_bad_s1 ? ST_SPAN : ST_OK) : st_f;
		era_s2 <= rev_s1 ? era_r : era_f;
		yoe_s2 <= YOE_W'(yy_s1 - era_yrs);
		yhi_s2 <= qyy_s1[1:0];
		doy_s2 <= doy_f;
		z_s2   <= z_s1;
		cnt_s2 <= cnt_s1;
	end

	// ---------------- stage 3: era days, day of era ----------------
	logic [Z_W-1:0]   edays;
	logic [DOE_W-1:0] doe_f;

	assign edays = Z_W'(era_s2 * 18'(ERA_DAYS));
	assign doe_f = DOE_W'(yoe_s2 * 9'(YEAR_DAYS)) + DOE_W'(yoe_s2 >> 2)
		- DOE_W'(yhi_s2) + DOE_W'(doy_s2);

	always_ff @(posedge clk) begin
		rev_s3   <= rev_s2;
		st_s3    <= st_s2;
		era_s3   <= era_s2;
		edays_s3 <= edays;
		doe_s3   <= rev_s2 ? DOE_W'(z_s2 - edays) : doe_f;
		cnt_s3   <= cnt_s2;
	end

	// ---------------- stage 4: forward count, leap-correction quotients ----------------
	logic [6:0] qa;
	logic [2:0] qb;
	logic       qc;

	gdc_cdiv #(.N(DOE_W), .D(1460),   .QW(7)) u_div_a (.x(doe_s3), .q(qa));
	gdc_cdiv #(.N(DOE_W), .D(36524),  .QW(3)) u_div_b (.x(doe_s3), .q(qb));
	gdc_cdiv #(.N(DOE_W), .D(146096), .QW(1)) u_div_c (.x(doe_s3), .q(qc));

	always_ff @(posedge clk) begin
		rev_s4 <= rev_s3;
		st_s4  <= st_s3;
		era_s4 <= era_s3;
		doe_s4 <= doe_s3;
		qa_s4  <= qa;
		qb_s4  <= qb;
		qc_s4  <= qc;
		cnt_s4 <= rev_s3 ? cnt_s3
			: ({1'b0, edays_s3} + CNT_W'(doe_s3) - CNT_W'(EPOCH_OFS));
	end

	// ---------------- stage 5: corrected day of era ----------------
	always_ff @(posedge clk) begin
		rev_s5 <= rev_s4;
		st_s5  <= st_s4;
		era_s5 <= era_s4;
		doe_s5 <= doe_s4;
		t_s5   <= doe_s4 - DOE_W'(qa_s4) + DOE_W'(qb_s4) - DOE_W'(qc_s4);
		cnt_s5 <= cnt_s4;
	end

	// ---------------- stage 6: year of era ----------------
	logic [YOE_W-1:0] yoe_r;

	gdc_cdiv #(.N(DOE_W), .D(YEAR_DAYS), .QW(YOE_W)) u_div_yoe (.x(t_s5), .q(yoe_r));

	always_ff @(posedge clk) begin
		rev_s6 <= rev_s5;
		st_s6  <= st_s5;
		era_s6 <= era_s5;
		doe_s6 <= doe_s5;
		yoe_s6 <= yoe_r;
		cnt_s6 <= cnt_s5;
	end

	// ---------------- stage 7: day of year, March-based year ----------------
	logic [1:0]       yoe_cent;
	logic [DOE_W-1:0] ystart;

	gdc_cdiv #(.N(YOE_W), .D(CENT_YEARS), .QW(2)) u_div_cent (.x(yoe_s6), .q(yoe_cent));

	assign ystart = DOE_W'(yoe_s6 * 9'(YEAR_DAYS)) + DOE_W'(yoe_s6 >> 2) - DOE_W'(yoe_cent);

	always_ff @(posedge clk) begin
		rev_s7 <= rev_s6;
		st_s7  <= st_s6;
		doy_s7 <= DOY_W'(doe_s6 - ystart);
		yy_s7  <= YEAR_W'(yoe_s6) + YEAR_W'(era_s6 * 9'(ERA_YEARS));
		cnt_s7 <= cnt_s6;
	end

	// ---------------- stage 8: March-based month ----------------
	logic [10:0]        mp_num;
	logic [MONTH_W-1:0] mp;

	assign mp_num = 11'(doy_s7 * 3'd5) + 11'd2;

	gdc_cdiv #(.N(11), .D(153), .QW(MONTH_W)) u_div_mp (.x(mp_num), .q(mp));

	always_ff @(posedge clk) begin
		rev_s8 <= rev_s7;
		st_s8  <= st_s7;
		mp_s8  <= mp;
		doy_s8 <= doy_s7;
		yy_s8  <= yy_s7;
		cnt_s8 <= cnt_s7;
	end

	// ---------------- stage 9: civil date, result register ----------------
	logic [MONTH_W-1:0] mm_r;
	logic [DAY_W-1:0]   dd_r;
	logic [YEAR_W-1:0]  yr_r;

	assign mm_r = (mp_s8 < 4'd10) ? (mp_s8 + 4'd3) : (mp_s8 - 4'd9);
	assign dd_r = DAY_W'(doy_s8 - march_start(mp_s8) + 9'd1);
	assign yr_r = yy_s8 + YEAR_W'(mm_r <= 4'd2);

	always_ff @(posedge clk) begin
		st_s9    <= st_s8;
		cnt_s9   <= (st_s8 == ST_OK) ? cnt_s8 : '0;
		year_s9  <= (st_s8 == ST_OK && rev_s8) ? yr_r : '0;
		month_s9 <= (st_s8 == ST_OK && rev_s8) ? mm_r : '0;
		day_s9   <= (st_s8 == ST_OK && rev_s8) ? dd_r : '0;
	end

	// ---------------- result ports ----------------
	assign done          = v_s9;
	assign status        = st_s9;
	assign out_day_count = cnt_s9;
	assign out_year      = year_s9;
	assign out_month     = month_s9;
	assign out_day       = day_s9;

endmodule

`default_nettype wire

// File: tb/sv/gregorian_date_day_number_converter_unit_tb.sv
// Self-checking testbench for gregorian_date_day_number_converter_unit: drives
// date and day-count beats, predicts each result and checks every done beat.
// Depends on gdc_pkg and the converter RTL.

module gregorian_date_day_number_converter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Request directions
	localparam logic REQ_TO_COUNT = 1'b0;
	localparam logic REQ_TO_DATE  = 1'b1;

	// Era arithmetic constants (March-based years, 400-year eras)
	localparam int ERA_LEN      = 146097;
	localparam int ERA_LAST_DAY = 146096;
	localparam int CENTURY_LEN  = 36524;
	localparam int QUAD_LEN     = 1460;
	localparam int EPOCH_SHIFT  = 719468;
	localparam int SPAN_DAYS    = 3652058;   // CNT_HI - CNT_LO

	localparam int RESULT_LATENCY = 9;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS    = 40;
	localparam int PHASE_BEATS    = 460;

	typedef struct {
		gdc_pkg::status_t                       status;
		logic signed [gdc_pkg::CNT_W-1:0]       day_count;
		logic [gdc_pkg::YEAR_W-1:0]             year;
		logic [gdc_pkg::MONTH_W-1:0]            month;
		logic [gdc_pkg::DAY_W-1:0]              day;
	} civil_result_t;

	// Calendar converter model plus in-order store of pending results
	class date_scoreboard;
		civil_result_t pending_q[$];
		int mismatches;

		function bit leap_year(int y);
			return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
		endfunction

		function int month_days(int y, int m);
			case (m)
				2:             return leap_year(y) ? 29 : 28;
				4, 6, 9, 11:   return 30;
				default:       return 31;
			endcase
		endfunction

		function civil_result_t convert(logic rt, logic [gdc_pkg::YEAR_W-1:0] y,
				logic [gdc_pkg::MONTH_W-1:0] m, logic [gdc_pkg::DAY_W-1:0] d,
				logic signed [gdc_pkg::CNT_W-1:0] n);
			civil_result_t r;
			int yy, era, yoe, mar, doy, doe, z, mp;
			r.status    = gdc_pkg::ST_OK;
			r.day_count = '0;
			r.year      = '0;
			r.month     = '0;
			r.day       = '0;
			if (rt == REQ_TO_COUNT) begin
				// checks in priority order: year, month, day zero, day too large
				if (y < 1 || y > gdc_pkg::YEAR_MAX) begin
					r.status = gdc_pkg::ST_BAD_YEAR;
				end else if (m < 1 || m > 12) begin
					r.status = gdc_pkg::ST_BAD_MONTH;
				end else if (d == 0) begin
					r.status = gdc_pkg::ST_DAY_ZERO;
				end else if (int'(d) > month_days(int'(y), int'(m))) begin
					r.status = gdc_pkg::ST_DAY_OVER;
				end else begin
					yy  = int'(y) - ((m <= 2) ? 1 : 0);
					era = yy / 400;
					yoe = yy - era * 400;
					mar = (m > 2) ? int'(m) - 3 : int'(m) + 9;
					doy = (153 * mar + 2) / 5 + int'(d) - 1;
					doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
					r.day_count = gdc_pkg::CNT_W'(era * ERA_LEN + doe - EPOCH_SHIFT);
				end
			end else begin
				if (n < gdc_pkg::CNT_LO || n > gdc_pkg::CNT_HI) begin
					r.status = gdc_pkg::ST_SPAN;
				end else begin
					z   = int'(n) + EPOCH_SHIFT;
					era = z / ERA_LEN;
					doe = z - era * ERA_LEN;
					yoe = (doe - doe / QUAD_LEN + doe / CENTURY_LEN - doe / ERA_LAST_DAY) / 365;
					doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
					mp  = (5 * doy + 2) / 153;
					mar = (mp < 10) ? mp + 3 : mp - 9;
					r.day_count = n;
					r.day       = gdc_pkg::DAY_W'(doy - (153 * mp + 2) / 5 + 1);
					r.month     = gdc_pkg::MONTH_W'(mar);
					r.year      = gdc_pkg::YEAR_W'(yoe + era * 400 + ((mar <= 2) ? 1 : 0));
				end
			end
			return r;
		endfunction

		function void note_input(logic rt, logic [gdc_pkg::YEAR_W-1:0] y,
				logic [gdc_pkg::MONTH_W-1:0] m, logic [gdc_pkg::DAY_W-1:0] d,
				logic signed [gdc_pkg::CNT_W-1:0] n);
			pending_q.push_back(convert(rt, y, m, d, n));
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function void compare_field(string field, logic signed [23:0] expv,
				logic signed [23:0] actv);
			if (expv !== actv) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
			end
		endfunction

		function void check_result(logic [2:0] st, logic signed [gdc_pkg::CNT_W-1:0] cnt,
				logic [gdc_pkg::YEAR_W-1:0] y, logic [gdc_pkg::MONTH_W-1:0] m,
				logic [gdc_pkg::DAY_W-1:0] d);
			civil_result_t e;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result beat with nothing outstanding, expected none, got status %0d",
						$time, st);
				return;
			end
			e = pending_q.pop_front();
			compare_field("status", e.status, st);
			compare_field("out_day_count", e.day_count, cnt);
			compare_field("out_year", e.year, y);
			compare_field("out_month", e.month, m);
			compare_field("out_day", e.day, d);
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic req_type = REQ_TO_COUNT;
	logic [gdc_pkg::YEAR_W-1:0] in_year = '0;
	logic [gdc_pkg::MONTH_W-1:0] in_month = '0;
	logic [gdc_pkg::DAY_W-1:0] in_day = '0;
	logic signed [gdc_pkg::CNT_W-1:0] in_day_count = '0;
	logic busy, done;
	logic [2:0] status;
	logic signed [gdc_pkg::CNT_W-1:0] out_day_count;
	logic [gdc_pkg::YEAR_W-1:0] out_year;
	logic [gdc_pkg::MONTH_W-1:0] out_month;
	logic [gdc_pkg::DAY_W-1:0] out_day;

	date_scoreboard sb = new();
	int stall_cycles = 0;

	gregorian_date_day_number_converter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.in_year       (in_year),
		.in_month      (in_month),
		.in_day        (in_day),
		.in_day_count  (in_day_count),
		.done          (done),
		.status        (status),
		.out_day_count (out_day_count),
		.out_year      (out_year),
		.out_month     (out_month),
		.out_day       (out_day)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Beat monitor, result checker and watchdog on pre-edge values
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_input(req_type, in_year, in_month, in_day, in_day_count);
		if (arst_n && done)
			sb.check_result(status, out_day_count, out_year, out_month, out_day);
		if (arst_n && ((start && !busy) || done))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Present one beat and hold it until taken
	task automatic drive_beat(input logic rt, input logic [gdc_pkg::YEAR_W-1:0] y,
			input logic [gdc_pkg::MONTH_W-1:0] m, input logic [gdc_pkg::DAY_W-1:0] d,
			input logic signed [gdc_pkg::CNT_W-1:0] n);
		start        <= 1'b1;
		req_type     <= rt;
		in_year      <= y;
		in_month     <= m;
		in_day       <= d;
		in_day_count <= n;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle_for(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off the sender until every outstanding result is back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic random_beat(input int idle_pct);
		int kind, off;
		logic rt;
		logic [gdc_pkg::YEAR_W-1:0] y;
		logic [gdc_pkg::MONTH_W-1:0] m;
		logic [gdc_pkg::DAY_W-1:0] d;
		logic signed [gdc_pkg::CNT_W-1:0] n;
		// each cycle idles with the given chance
		while ($urandom_range(99) < idle_pct)
			idle_for(1);
		rt = 1'($urandom);
		y  = gdc_pkg::YEAR_W'($urandom);
		m  = gdc_pkg::MONTH_W'($urandom);
		d  = gdc_pkg::DAY_W'($urandom);
		n  = gdc_pkg::CNT_W'($urandom);
		kind = int'($urandom_range(99));
		if (kind < 45) begin
			// plausible date; century years stress the leap rule
			rt = REQ_TO_COUNT;
			if ($urandom_range(3) == 0)
				y = gdc_pkg::YEAR_W'($urandom_range(1, 99) * 100);
			else
				y = gdc_pkg::YEAR_W'($urandom_range(1, gdc_pkg::YEAR_MAX));
			m = gdc_pkg::MONTH_W'($urandom_range(1, 12));
			d = ($urandom_range(19) == 0) ? '0 : gdc_pkg::DAY_W'($urandom_range(1, 31));
		end else if (kind < 85) begin
			// day count mostly inside the span, sometimes on or just past its ends
			rt = REQ_TO_DATE;
			case ($urandom_range(9))
				0:       off = int'($urandom_range(0, 3)) - 2;
				1:       off = SPAN_DAYS + int'($urandom_range(0, 3)) - 1;
				default: off = int'($urandom_range(0, SPAN_DAYS));
			endcase
			n = gdc_pkg::CNT_W'(int'(gdc_pkg::CNT_LO) + off);
		end
		drive_beat(rt, y, m, d, n);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: epoch, span ends, leap rule, each error in priority order
		drive_beat(REQ_TO_COUNT, 1970, 1, 1, 0);
		drive_beat(REQ_TO_COUNT, 1969, 12, 31, 0);
		drive_beat(REQ_TO_COUNT, 1, 1, 1, 0);
		drive_beat(REQ_TO_COUNT, 9999, 12, 31, 0);
		drive_beat(REQ_TO_COUNT, 0, 0, 0, 0);
		drive_beat(REQ_TO_COUNT, 10000, 1, 1, 0);
		drive_beat(REQ_TO_COUNT, 16383, 15, 31, 23'sh7FFFFF);
		drive_beat(REQ_TO_COUNT, 2023, 0, 0, 0);
		drive_beat(REQ_TO_COUNT, 2023, 13, 1, 0);
		drive_beat(REQ_TO_COUNT, 2023, 15, 31, 0);
		drive_beat(REQ_TO_COUNT, 2023, 5, 0, 0);
		drive_beat(REQ_TO_COUNT, 2023, 4, 31, 0);
		drive_beat(REQ_TO_COUNT, 2000, 2, 29, 0);
		drive_beat(REQ_TO_COUNT, 1900, 2, 29, 0);
		drive_beat(REQ_TO_COUNT, 2400, 2, 29, 0);
		drive_beat(REQ_TO_COUNT, 2023, 2, 29, 0);
		drive_beat(REQ_TO_COUNT, 2024, 2, 30, 0);
		drive_beat(REQ_TO_DATE, 0, 0, 0, 0);
		drive_beat(REQ_TO_DATE, 16383, 15, 31, -23'sd1);
		drive_beat(REQ_TO_DATE, 0, 0, 0, gdc_pkg::CNT_LO);
		drive_beat(REQ_TO_DATE, 0, 0, 0, gdc_pkg::CNT_HI);
		drive_beat(REQ_TO_DATE, 0, 0, 0, -23'sd719163);
		drive_beat(REQ_TO_DATE, 0, 0, 0, 23'sd2932897);
		drive_beat(REQ_TO_DATE, 0, 0, 0, 23'sh400000);
		drive_beat(REQ_TO_DATE, 0, 0, 0, 23'sh3FFFFF);
		drive_beat(REQ_TO_DATE, 0, 0, 0, 23'sd11016);
		drain();

		// Random: sender gaps light, then heavy, then back to back
		repeat (PHASE_BEATS) random_beat(18);
		drain();
		repeat (PHASE_BEATS) random_beat(48);
		drain();
		repeat (PHASE_BEATS) random_beat(0);
		drain();
		repeat (RESULT_LATENCY + 4) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/gdc_pkg.sv
hw/rtl/gdc_cdiv.sv
hw/rtl/gregorian_date_day_number_converter_unit.sv
tb/sv/gregorian_date_day_number_converter_unit_tb.sv
